// ===== src/bbs_pkg.sv =====
// ============================================================================
// bbs_pkg : shared types, constants and microcode for the ball bounce/spin step
// Command and status structs, slot map of the scratch store and the program ROM.
// ============================================================================
package bbs_pkg;

    localparam int WORD_W  = 32;
    localparam int FRAC_W  = 16;
    localparam int SLOT_W  = 5;
    localparam int DEPTH   = 32;
    localparam int PC_W    = 7;
    localparam int NSTATE  = 9;

    // register reset values
    localparam logic [30:0] RST_RADIUS   = 31'd5980160;
    localparam logic [30:0] RST_GAIN     = 31'd131072;
    localparam logic [16:0] RST_MU       = 17'd18678;
    localparam logic [16:0] RST_CR       = 17'd39322;
    localparam logic [23:0] RST_COUPLING = 24'd5033;

    localparam logic [16:0] ONE_FX = 17'd65536;

    typedef enum logic [2:0] {
        REG_RADIUS   = 3'd0,
        REG_GAIN     = 3'd1,
        REG_MU       = 3'd2,
        REG_CR       = 3'd3,
        REG_COUPLING = 3'd4
    } t_reg;

    localparam logic [2:0] KIND_TICK   = 3'd0;
    localparam logic [2:0] KIND_BOUNCE = 3'd1;
    localparam logic [2:0] KIND_LDP    = 3'd2;
    localparam logic [2:0] KIND_LDV    = 3'd3;
    localparam logic [2:0] KIND_LDW    = 3'd4;

    typedef enum logic [3:0] {
        OP_NOP, OP_LD, OP_ADD, OP_SUB, OP_NEG, OP_MUL, OP_MULR, OP_MULC,
        OP_MULG, OP_KF, OP_SQZ, OP_SQA, OP_SQRTP, OP_SQRTS, OP_YPD
    } t_op;

    typedef logic [SLOT_W-1:0] t_slot;

    typedef struct packed {
        t_op   op;
        t_slot dst;
        t_slot a;
        t_slot b;
        logic  last;
    } t_instr;

    typedef struct packed {
        logic   start;
        logic   rd;
        logic   ex;
        logic   publish;
        t_instr ins;
    } t_cmd;

    typedef struct packed {
        logic busy;
    } t_sts;

    typedef struct packed {
        logic [30:0] radius;
        logic [30:0] gain;
        logic [16:0] mu;
        logic [16:0] cr;
        logic [23:0] coupling;
    } t_cfg;

    typedef enum logic [2:0] {S_IDLE, S_RD, S_EX, S_WAIT, S_OUT} t_state;

    // scratch store slot map; state words first
    localparam t_slot P0 = 5'd0,  P1 = 5'd1,  P2 = 5'd2;
    localparam t_slot V0 = 5'd3,  V1 = 5'd4,  V2 = 5'd5;
    localparam t_slot W0 = 5'd6,  W1 = 5'd7,  W2 = 5'd8;
    localparam t_slot N0 = 5'd9,  N1 = 5'd10, N2 = 5'd11;
    localparam t_slot SD = 5'd12;
    localparam t_slot C0 = 5'd13, C1 = 5'd14, C2 = 5'd15;
    localparam t_slot Q0 = 5'd16, Q1 = 5'd17, Q2 = 5'd18;   // vperp
    localparam t_slot S0 = 5'd19, S1 = 5'd20, S2 = 5'd21;   // slip
    localparam t_slot E0 = 5'd22, E1 = 5'd23, E2 = 5'd24;   // dpara
    localparam t_slot T0 = 5'd25, T1 = 5'd26;
    localparam t_slot SK = 5'd27, SG = 5'd28;
    localparam t_slot X0 = 5'd0,  X1 = 5'd1,  X2 = 5'd2;    // input component

    localparam logic [PC_W-1:0] PC_TICK   = 7'd0;
    localparam logic [PC_W-1:0] PC_LDP    = 7'd4;
    localparam logic [PC_W-1:0] PC_LDV    = 7'd8;
    localparam logic [PC_W-1:0] PC_LDW    = 7'd12;
    localparam logic [PC_W-1:0] PC_BOUNCE = 7'd16;

    function automatic t_instr mk(input t_op op, input t_slot d, input t_slot a,
                                  input t_slot b, input logic l);
        t_instr r;
        r.op = op; r.dst = d; r.a = a; r.b = b; r.last = l;
        return r;
    endfunction

    function automatic t_instr rom(input logic [PC_W-1:0] pc);
        t_instr r;
        case (pc)
            7'd0:  r = mk(OP_ADD, P0, P0, V0, 1'b0);
            7'd1:  r = mk(OP_ADD, P1, P1, V1, 1'b0);
            7'd2:  r = mk(OP_ADD, P2, P2, V2, 1'b1);
            7'd4:  r = mk(OP_LD, P0, X0, X0, 1'b0);
            7'd5:  r = mk(OP_LD, P1, X1, X0, 1'b0);
            7'd6:  r = mk(OP_LD, P2, X2, X0, 1'b1);
            7'd8:  r = mk(OP_LD, V0, X0, X0, 1'b0);
            7'd9:  r = mk(OP_LD, V1, X1, X0, 1'b0);
            7'd10: r = mk(OP_LD, V2, X2, X0, 1'b1);
            7'd12: r = mk(OP_LD, W0, X0, X0, 1'b0);
            7'd13: r = mk(OP_LD, W1, X1, X0, 1'b0);
            7'd14: r = mk(OP_LD, W2, X2, X0, 1'b1);
            // bounce: latch normal
            7'd16: r = mk(OP_LD, N0, X0, X0, 1'b0);
            7'd17: r = mk(OP_LD, N1, X1, X0, 1'b0);
            7'd18: r = mk(OP_LD, N2, X2, X0, 1'b0);
            // d = v.n
            7'd19: r = mk(OP_MUL, T0, V0, N0, 1'b0);
            7'd20: r = mk(OP_MUL, T1, V1, N1, 1'b0);
            7'd21: r = mk(OP_ADD, SD, T0, T1, 1'b0);
            7'd22: r = mk(OP_MUL, T0, V2, N2, 1'b0);
            7'd23: r = mk(OP_ADD, SD, SD, T0, 1'b0);
            // c = n x w
            7'd24: r = mk(OP_MUL, T0, N1, W2, 1'b0);
            7'd25: r = mk(OP_MUL, T1, N2, W1, 1'b0);
            7'd26: r = mk(OP_SUB, C0, T0, T1, 1'b0);
            7'd27: r = mk(OP_MUL, T0, N2, W0, 1'b0);
            7'd28: r = mk(OP_MUL, T1, N0, W2, 1'b0);
            7'd29: r = mk(OP_SUB, C1, T0, T1, 1'b0);
            7'd30: r = mk(OP_MUL, T0, N0, W1, 1'b0);
            7'd31: r = mk(OP_MUL, T1, N1, W0, 1'b0);
            7'd32: r = mk(OP_SUB, C2, T0, T1, 1'b0);
            // vperp, slip
            7'd33: r = mk(OP_MUL, Q0, SD, N0, 1'b0);
            7'd34: r = mk(OP_SUB, S0, V0, Q0, 1'b0);
            7'd35: r = mk(OP_MULR, T0, C0, C0, 1'b0);
            7'd36: r = mk(OP_ADD, S0, S0, T0, 1'b0);
            7'd37: r = mk(OP_MUL, Q1, SD, N1, 1'b0);
            7'd38: r = mk(OP_SUB, S1, V1, Q1, 1'b0);
            7'd39: r = mk(OP_MULR, T0, C1, C1, 1'b0);
            7'd40: r = mk(OP_ADD, S1, S1, T0, 1'b0);
            7'd41: r = mk(OP_MUL, Q2, SD, N2, 1'b0);
            7'd42: r = mk(OP_SUB, S2, V2, Q2, 1'b0);
            7'd43: r = mk(OP_MULR, T0, C2, C2, 1'b0);
            7'd44: r = mk(OP_ADD, S2, S2, T0, 1'b0);
            // magnitudes
            7'd45: r = mk(OP_SQZ, T0, T0, T0, 1'b0);
            7'd46: r = mk(OP_SQA, T0, Q0, Q0, 1'b0);
            7'd47: r = mk(OP_SQA, T0, Q1, Q1, 1'b0);
            7'd48: r = mk(OP_SQA, T0, Q2, Q2, 1'b0);
            7'd49: r = mk(OP_SQRTP, T0, T0, T0, 1'b0);
            7'd50: r = mk(OP_SQZ, T0, T0, T0, 1'b0);
            7'd51: r = mk(OP_SQA, T0, S0, S0, 1'b0);
            7'd52: r = mk(OP_SQA, T0, S1, S1, 1'b0);
            7'd53: r = mk(OP_SQA, T0, S2, S2, 1'b0);
            7'd54: r = mk(OP_SQRTS, T0, T0, T0, 1'b0);
            7'd55: r = mk(OP_YPD, T0, T0, T0, 1'b0);
            7'd56: r = mk(OP_KF, SK, T0, T0, 1'b0);
            // impulse and position, per axis
            7'd57: r = mk(OP_MULC, T0, Q0, Q0, 1'b0);
            7'd58: r = mk(OP_NEG, T0, T0, T0, 1'b0);
            7'd59: r = mk(OP_MUL, T1, SK, S0, 1'b0);
            7'd60: r = mk(OP_NEG, E0, T1, T1, 1'b0);
            7'd61: r = mk(OP_ADD, P0, P0, V0, 1'b0);
            7'd62: r = mk(OP_ADD, V0, V0, T0, 1'b0);
            7'd63: r = mk(OP_ADD, V0, V0, E0, 1'b0);
            7'd64: r = mk(OP_MULC, T0, Q1, Q1, 1'b0);
            7'd65: r = mk(OP_NEG, T0, T0, T0, 1'b0);
            7'd66: r = mk(OP_MUL, T1, SK, S1, 1'b0);
            7'd67: r = mk(OP_NEG, E1, T1, T1, 1'b0);
            7'd68: r = mk(OP_ADD, P1, P1, V1, 1'b0);
            7'd69: r = mk(OP_ADD, V1, V1, T0, 1'b0);
            7'd70: r = mk(OP_ADD, V1, V1, E1, 1'b0);
            7'd71: r = mk(OP_MULC, T0, Q2, Q2, 1'b0);
            7'd72: r = mk(OP_NEG, T0, T0, T0, 1'b0);
            7'd73: r = mk(OP_MUL, T1, SK, S2, 1'b0);
            7'd74: r = mk(OP_NEG, E2, T1, T1, 1'b0);
            7'd75: r = mk(OP_ADD, P2, P2, V2, 1'b0);
            7'd76: r = mk(OP_ADD, V2, V2, T0, 1'b0);
            7'd77: r = mk(OP_ADD, V2, V2, E2, 1'b0);
            // spin: w += g * (dpara x n)
            7'd78: r = mk(OP_MULG, SG, T0, T0, 1'b0);
            7'd79: r = mk(OP_MUL, T0, E1, N2, 1'b0);
            7'd80: r = mk(OP_MUL, T1, E2, N1, 1'b0);
            7'd81: r = mk(OP_SUB, C0, T0, T1, 1'b0);
            7'd82: r = mk(OP_MUL, T0, E2, N0, 1'b0);
            7'd83: r = mk(OP_MUL, T1, E0, N2, 1'b0);
            7'd84: r = mk(OP_SUB, C1, T0, T1, 1'b0);
            7'd85: r = mk(OP_MUL, T0, E0, N1, 1'b0);
            7'd86: r = mk(OP_MUL, T1, E1, N0, 1'b0);
            7'd87: r = mk(OP_SUB, C2, T0, T1, 1'b0);
            7'd88: r = mk(OP_MUL, T0, SG, C0, 1'b0);
            7'd89: r = mk(OP_ADD, W0, W0, T0, 1'b0);
            7'd90: r = mk(OP_MUL, T0, SG, C1, 1'b0);
            7'd91: r = mk(OP_ADD, W1, W1, T0, 1'b0);
            7'd92: r = mk(OP_MUL, T0, SG, C2, 1'b0);
            7'd93: r = mk(OP_ADD, W2, W2, T0, 1'b1);
            default: r = mk(OP_NOP, T0, T0, T0, 1'b1);
        endcase
        return r;
    endfunction

endpackage

// ===== src/bbs_datapath.sv =====
// ============================================================================
// bbs_datapath : scratch store, shared multiplier/ALU, root and fraction units
// Executes one microcode word per command; holds state mirror and result word.
// ============================================================================
module bbs_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bbs_pkg::t_cmd      i_cmd,
    input  bbs_pkg::t_cfg      i_cfg,
    input  logic signed [31:0] i_vec_x,
    input  logic signed [31:0] i_vec_y,
    input  logic signed [31:0] i_vec_z,
    output bbs_pkg::t_sts      o_sts,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic signed [31:0] o_pos_z,
    output logic signed [31:0] o_vel_x,
    output logic signed [31:0] o_vel_y,
    output logic signed [31:0] o_vel_z,
    output logic signed [31:0] o_spin_x,
    output logic signed [31:0] o_spin_y,
    output logic signed [31:0] o_spin_z,
    output logic               o_saturated
);
    import bbs_pkg::*;

    localparam logic signed [65:0] WMAX = 66'sd2147483647;
    localparam logic signed [65:0] WMIN = -66'sd2147483648;

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]  r_vld;
    logic [WORD_W-1:0] r_rda, r_rdb;
    logic              r_va, r_vb;
    logic [WORD_W-1:0] r_in [3];
    logic [WORD_W-1:0] r_st [NSTATE];
    logic [WORD_W-1:0] r_out [NSTATE];
    logic              r_out_sat;
    logic              r_sat;

    logic [63:0]       r_acc;
    logic [31:0]       r_magp, r_mags;
    logic [16:0]       r_factor;

    // iterative units
    logic              r_sq_run, r_sq_tgt, r_dv_run;
    logic [4:0]        r_cnt;
    logic [63:0]       r_src;
    logic [35:0]       r_rem;
    logic [31:0]       r_root;
    logic [31:0]       r_drem;
    logic [15:0]       r_q;

    t_instr            ins;
    logic signed [31:0] opa, opb;
    logic signed [32:0] ma, mb;
    logic signed [65:0] prod, biased, shifted;
    logic               sh24;
    logic [31:0]        wdata;
    logic               we, satf;
    logic signed [32:0] sum, dif;
    logic signed [65:0] yp;
    logic               yp_one;

    logic [35:0]        rem_sh, trial;
    logic               rt_ge;
    logic [31:0]        dv_diff;
    logic               dv_ge;

    assign ins = i_cmd.ins;
    assign opa = r_va ? r_rda : '0;
    assign opb = r_vb ? r_rdb : '0;

    // shared multiplier with truncation toward zero
    always_comb begin
        ma   = {opa[31], opa};
        mb   = {opb[31], opb};
        sh24 = 1'b0;
        case (ins.op)
            OP_MULR: mb = {2'b00, i_cfg.radius};
            OP_MULC: mb = 33'(ONE_FX) + 33'(i_cfg.cr);
            OP_MULG: begin
                ma   = {9'd0, i_cfg.coupling};
                mb   = {2'b00, i_cfg.radius};
                sh24 = 1'b1;
            end
            OP_KF: begin
                ma = {16'd0, r_factor};
                mb = {16'd0, i_cfg.mu};
            end
            OP_SQA: mb = ma;
            OP_YPD: begin
                ma = {2'b00, i_cfg.gain};
                mb = {1'b0, r_magp};
            end
            default: ;
        endcase
        prod    = ma * mb;
        biased  = prod + ((prod < 0) ? (sh24 ? 66'sd16777215 : 66'sd65535) : 66'sd0);
        shifted = sh24 ? (biased >>> 24) : (biased >>> FRAC_W);
    end

    assign yp     = shifted;
    assign yp_one = (r_mags == '0) || (yp >= $signed({34'd0, r_mags}));
    assign sum    = {opa[31], opa} + {opb[31], opb};
    assign dif    = {opa[31], opa} - {opb[31], opb};

    always_comb begin
        wdata = '0;
        we    = 1'b0;
        satf  = 1'b0;
        case (ins.op)
            OP_LD: begin
                we = 1'b1;
                case (ins.a[1:0])
                    2'd0:    wdata = r_in[0];
                    2'd1:    wdata = r_in[1];
                    default: wdata = r_in[2];
                endcase
            end
            OP_ADD: begin
                we = 1'b1;
                satf  = sum[32] != sum[31];
                wdata = satf ? (sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : sum[31:0];
            end
            OP_SUB: begin
                we = 1'b1;
                satf  = dif[32] != dif[31];
                wdata = satf ? (dif[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : dif[31:0];
            end
            OP_NEG: begin
                we = 1'b1;
                satf  = opa == 32'sh8000_0000;
                wdata = satf ? 32'h7FFF_FFFF : 32'(-opa);
            end
            OP_MUL, OP_MULR, OP_MULC, OP_MULG: begin
                we = 1'b1;
                if (shifted > WMAX) begin
                    satf = 1'b1; wdata = 32'h7FFF_FFFF;
                end else if (shifted < WMIN) begin
                    satf = 1'b1; wdata = 32'h8000_0000;
                end else begin
                    wdata = shifted[31:0];
                end
            end
            OP_KF: begin
                // factor <= 1 and mu < 2, never clamps
                we    = 1'b1;
                wdata = shifted[31:0];
            end
            default: ;
        endcase
    end

    // root step: two radicand bits per cycle
    assign rem_sh = {r_rem[33:0], r_src[63:62]};
    assign trial  = {2'b00, r_root, 2'b01};
    assign rt_ge  = rem_sh >= trial;
    // fraction step: rem stays below den
    assign dv_diff = r_mags - r_drem;
    assign dv_ge   = r_drem >= dv_diff;

    // scratch store
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rda <= r_mem[ins.a];
            r_rdb <= r_mem[ins.b];
            r_va  <= r_vld[ins.a];
            r_vb  <= r_vld[ins.b];
        end
        if (i_cmd.ex && we) begin
            r_mem[ins.dst] <= wdata;
        end
        if (i_cmd.start) begin
            r_in[0] <= i_vec_x;
            r_in[1] <= i_vec_y;
            r_in[2] <= i_vec_z;
        end
        if (i_cmd.publish) begin
            r_out     <= r_st;
            r_out_sat <= r_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_sat <= 1'b0;
            for (int i = 0; i < NSTATE; i++) begin
                r_st[i] <= '0;
            end
        end else begin
            if (i_cmd.start) begin
                r_sat <= 1'b0;
            end else if (i_cmd.ex && satf) begin
                r_sat <= 1'b1;
            end
            if (i_cmd.ex && we) begin
                r_vld[ins.dst] <= 1'b1;
                for (int i = 0; i < NSTATE; i++) begin
                    if (ins.dst == SLOT_W'(i)) begin
                        r_st[i] <= wdata;
                    end
                end
            end
        end
    end

    // accumulator and iterative units
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_run <= 1'b0;
            r_dv_run <= 1'b0;
        end else begin
            if (i_cmd.ex) begin
                case (ins.op)
                    OP_SQZ: r_acc <= '0;
                    OP_SQA: r_acc <= r_acc + prod[63:0];
                    OP_SQRTP, OP_SQRTS: begin
                        r_src    <= r_acc;
                        r_rem    <= '0;
                        r_root   <= '0;
                        r_cnt    <= 5'd31;
                        r_sq_run <= 1'b1;
                        r_sq_tgt <= ins.op == OP_SQRTS;
                    end
                    OP_YPD: begin
                        if (yp_one) begin
                            r_factor <= ONE_FX;
                        end else begin
                            r_drem   <= yp[31:0];
                            r_q      <= '0;
                            r_cnt    <= 5'd15;
                            r_dv_run <= 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            if (r_sq_run) begin
                r_src  <= {r_src[61:0], 2'b00};
                r_rem  <= rt_ge ? rem_sh - trial : rem_sh;
                r_root <= {r_root[30:0], rt_ge};
                r_cnt  <= r_cnt - 5'd1;
                if (r_cnt == '0) begin
                    r_sq_run <= 1'b0;
                    if (r_sq_tgt) begin
                        r_mags <= {r_root[30:0], rt_ge};
                    end else begin
                        r_magp <= {r_root[30:0], rt_ge};
                    end
                end
            end
            if (r_dv_run) begin
                r_drem <= dv_ge ? r_drem - dv_diff : {r_drem[30:0], 1'b0};
                r_q    <= {r_q[14:0], dv_ge};
                r_cnt  <= r_cnt - 5'd1;
                if (r_cnt == '0) begin
                    r_dv_run <= 1'b0;
                    r_factor <= {1'b0, r_q[14:0], dv_ge};
                end
            end
        end
    end

    assign o_sts.busy  = r_sq_run | r_dv_run;
    assign o_pos_x     = r_out[0];
    assign o_pos_y     = r_out[1];
    assign o_pos_z     = r_out[2];
    assign o_vel_x     = r_out[3];
    assign o_vel_y     = r_out[4];
    assign o_vel_z     = r_out[5];
    assign o_spin_x    = r_out[6];
    assign o_spin_y    = r_out[7];
    assign o_spin_z    = r_out[8];
    assign o_saturated = r_out_sat;

endmodule

// ===== src/bbs_ctrl.sv =====
// ============================================================================
// bbs_ctrl : sequencer for the ball step
// Walks the microcode ROM, waits on the iterative units, owns both handshakes.
// ============================================================================
module bbs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [2:0]    i_kind,
    output logic          o_stall,
    output logic          o_valid,
    input  logic          i_stall,
    input  bbs_pkg::t_sts i_sts,
    output bbs_pkg::t_cmd o_cmd
);
    import bbs_pkg::*;

    t_state          r_state, n_state;
    logic [PC_W-1:0] r_pc, n_pc;
    logic            r_out_valid, n_out_valid;
    t_instr          cur_ins;
    t_op             cur_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pc        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pc        <= n_pc;
            r_out_valid <= n_out_valid;
        end
    end

    assign cur_ins = rom(r_pc);
    assign cur_op  = cur_ins.op;

    always_comb begin
        n_state       = r_state;
        n_pc          = r_pc;
        o_cmd         = '0;
        o_cmd.ins     = cur_ins;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_RD;
                    case (i_kind)
                        KIND_TICK:   n_pc = PC_TICK;
                        KIND_BOUNCE: n_pc = PC_BOUNCE;
                        KIND_LDP:    n_pc = PC_LDP;
                        KIND_LDV:    n_pc = PC_LDV;
                        KIND_LDW:    n_pc = PC_LDW;
                        default:     n_state = S_OUT;
                    endcase
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_EX;
            end
            S_EX: begin
                o_cmd.ex = 1'b1;
                if (cur_op == OP_SQRTP || cur_op == OP_SQRTS || cur_op == OP_YPD) begin
                    n_state = S_WAIT;
                end else if (cur_ins.last) begin
                    n_state = S_OUT;
                end else begin
                    n_pc    = r_pc + 1'b1;
                    n_state = S_RD;
                end
            end
            S_WAIT: begin
                if (!i_sts.busy) begin
                    n_pc    = r_pc + 1'b1;
                    n_state = S_RD;
                end
            end
            S_OUT: begin
                if (!r_out_valid || !i_stall) begin
                    o_cmd.publish = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_out_valid = o_cmd.publish | (r_out_valid & i_stall);
    end

    assign o_stall = r_state != S_IDLE;
    assign o_valid = r_out_valid;

`ifndef SYNTH
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !i_sts.busy)
        else $error("iterative unit running while idle");
    a_ex_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EX) |-> ($past(r_state) == S_RD))
        else $error("execute without operand read");
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && r_state == S_IDLE) |=> (r_state != S_IDLE))
        else $error("accepted word not started");
`endif

endmodule

// ===== src/ball_bounce_spin_step.sv =====
// ============================================================================
// ball_bounce_spin_step : ball position/velocity/spin stepper with bounce
// Top level: register port, sequencer and datapath.
// ============================================================================
// Keeps a ball's position, velocity and spin as Q16.16 three-vectors and
// returns the whole state after every input word. A tick adds velocity to
// position; a bounce reflects velocity off the given normal with restitution,
// applies slip friction and couples the friction change into spin; the load
// kinds overwrite one vector; unused kinds return the state unchanged.
// One word is worked at a time. Each microcode step is an operand read from
// the scratch store, then one pass through the shared multiplier/ALU; each
// word is accepted first and published last. A bounce runs 78 steps plus
// two square-root waits and a fraction wait (the fraction unit does not run
// when friction is full). The next word is taken as soon as the previous
// one is published, even while its result still waits.
// Registers (32-bit APB, byte address 4*i): radius, slip ratio gain,
// friction, restitution, spin coupling; write them only while idle.
// ============================================================================
module ball_bounce_spin_step (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input words
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [2:0]         i_kind,
    input  logic signed [31:0] i_vec_x,
    input  logic signed [31:0] i_vec_y,
    input  logic signed [31:0] i_vec_z,
    // result words
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic signed [31:0] o_pos_z,
    output logic signed [31:0] o_vel_x,
    output logic signed [31:0] o_vel_y,
    output logic signed [31:0] o_vel_z,
    output logic signed [31:0] o_spin_x,
    output logic signed [31:0] o_spin_y,
    output logic signed [31:0] o_spin_z,
    output logic               o_saturated,
    // register port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import bbs_pkg::*;

    t_cfg r_cfg;
    t_cmd cmd;
    t_sts sts;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    // register file; unknown offsets are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.radius   <= RST_RADIUS;
            r_cfg.gain     <= RST_GAIN;
            r_cfg.mu       <= RST_MU;
            r_cfg.cr       <= RST_CR;
            r_cfg.coupling <= RST_COUPLING;
        end else if (wr_en) begin
            case (t_reg'(paddr[4:2]))
                REG_RADIUS:   r_cfg.radius   <= pwdata[30:0];
                REG_GAIN:     r_cfg.gain     <= pwdata[30:0];
                REG_MU:       r_cfg.mu       <= pwdata[16:0];
                REG_CR:       r_cfg.cr       <= pwdata[16:0];
                REG_COUPLING: r_cfg.coupling <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (t_reg'(paddr[4:2]))
            REG_RADIUS:   prdata = {1'b0, r_cfg.radius};
            REG_GAIN:     prdata = {1'b0, r_cfg.gain};
            REG_MU:       prdata = {15'd0, r_cfg.mu};
            REG_CR:       prdata = {15'd0, r_cfg.cr};
            REG_COUPLING: prdata = {8'd0, r_cfg.coupling};
            default:      prdata = '0;
        endcase
    end

    bbs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_kind  (i_kind),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    bbs_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cfg       (r_cfg),
        .i_vec_x     (i_vec_x),
        .i_vec_y     (i_vec_y),
        .i_vec_z     (i_vec_z),
        .o_sts       (sts),
        .o_pos_x     (o_pos_x),
        .o_pos_y     (o_pos_y),
        .o_pos_z     (o_pos_z),
        .o_vel_x     (o_vel_x),
        .o_vel_y     (o_vel_y),
        .o_vel_z     (o_vel_z),
        .o_spin_x    (o_spin_x),
        .o_spin_y    (o_spin_y),
        .o_spin_z    (o_spin_z),
        .o_saturated (o_saturated)
    );

endmodule

// ===== verif/testbench.sv =====
// ============================================================================
// testbench : self-checking bench for ball_bounce_spin_step
// Drives tick, bounce, load and spare-kind words with random idling on both channels,
// predicts the full ball state after every word and checks each result word.
// ============================================================================
module testbench;
    import bbs_pkg::*;

    localparam longint WMAX = 64'sd2147483647;
    localparam longint WMIN = -64'sd2147483648;
    localparam longint ONE  = 64'sd65536;
    localparam logic [2:0] KIND_SPARE_LO = 3'd5;
    localparam logic [2:0] KIND_SPARE_HI = 3'd7;
    localparam logic [2:0] REG_UNMAPPED  = 3'd5;
    localparam int N_RANDOM = 430;

    // one result word: pos xyz, vel xyz, spin xyz, then the flag
    typedef struct {
        logic [31:0] f [9];
        bit          sat;
    } t_ball_state;

    typedef struct {
        logic [2:0]  kind;
        logic [31:0] x, y, z;
        bit          typed;
        t_ball_state want;
    } t_stim_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [2:0]         i_kind = KIND_TICK;
    logic signed [31:0] i_vec_x = '0, i_vec_y = '0, i_vec_z = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [31:0] o_pos_x, o_pos_y, o_pos_z;
    logic signed [31:0] o_vel_x, o_vel_y, o_vel_z;
    logic signed [31:0] o_spin_x, o_spin_y, o_spin_z;
    logic               o_saturated;
    logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    ball_bounce_spin_step dut (.*);

    always #2 i_clk = ~i_clk;

    // run limit: covers every word as a full bounce under stalls
    initial begin
        #4000000;
        $display("[ball_bounce_spin_step] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // predictor: own copy of the ball state and registers
    // ------------------------------------------------------------------
    longint      ball_pos [3], ball_vel [3], ball_spin [3];
    logic [30:0] cfg_radius, cfg_gain;
    logic [16:0] cfg_mu, cfg_cr;
    logic [23:0] cfg_coupling;

    t_ball_state expected_states [$];
    int          n_fail = 0, n_checked = 0, n_bounce = 0, n_sat = 0;
    bit          quiet_run = 1'b0;
    string       field_name [9] = '{"pos_x", "pos_y", "pos_z", "vel_x", "vel_y",
                                    "vel_z", "spin_x", "spin_y", "spin_z"};

    function automatic longint unsigned mag_of(longint a);
        return a < 0 ? longint'(-a) : a;
    endfunction

    function automatic longint clamp_word(longint a, inout bit sat);
        if (a > WMAX) begin sat = 1'b1; return WMAX; end
        if (a < WMIN) begin sat = 1'b1; return WMIN; end
        return a;
    endfunction

    // exact product, shifted toward zero, clamped
    function automatic longint fx_mul(longint a, longint b, int sh, inout bit sat);
        logic [127:0]    p;
        longint unsigned lim;
        bit              neg;
        neg = (a < 0) != (b < 0);
        p   = ({64'b0, mag_of(a)} * {64'b0, mag_of(b)}) >> sh;
        lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        if (p > {64'b0, lim}) begin
            sat = 1'b1;
            return neg ? WMIN : WMAX;
        end
        return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    function automatic longint fx_add(longint a, longint b, inout bit sat);
        return clamp_word(a + b, sat);
    endfunction

    function automatic longint fx_sub(longint a, longint b, inout bit sat);
        return clamp_word(a - b, sat);
    endfunction

    function automatic void cross_fx(input longint a [3], input longint b [3],
                                     output longint r [3], inout bit sat);
        r[0] = fx_sub(fx_mul(a[1], b[2], FRAC_W, sat), fx_mul(a[2], b[1], FRAC_W, sat), sat);
        r[1] = fx_sub(fx_mul(a[2], b[0], FRAC_W, sat), fx_mul(a[0], b[2], FRAC_W, sat), sat);
        r[2] = fx_sub(fx_mul(a[0], b[1], FRAC_W, sat), fx_mul(a[1], b[0], FRAC_W, sat), sat);
    endfunction

    // floor of the euclidean length, exact
    function automatic longint unsigned vec_length(longint a [3]);
        logic [127:0]    sum, tt;
        longint unsigned r, t;
        sum = '0;
        r   = 0;
        for (int i = 0; i < 3; i++)
            sum += {64'b0, mag_of(a[i])} * {64'b0, mag_of(a[i])};
        for (int b = 63; b >= 0; b--) begin
            t  = r | (64'd1 << b);
            tt = {64'b0, t} * {64'b0, t};
            if (tt <= sum) r = t;
        end
        return r;
    endfunction

    // num/den as a 16-bit fraction, num < den
    function automatic longint slip_fraction(longint unsigned num, longint unsigned den);
        longint unsigned q, rem;
        q   = 0;
        rem = num;
        for (int i = 0; i < FRAC_W; i++) begin
            if (rem >= den - rem) begin
                rem = rem - (den - rem);
                q   = (q << 1) | 1;
            end else begin
                rem = rem + rem;
                q   = q << 1;
            end
        end
        return longint'(q);
    endfunction

    function automatic void bounce_ball(longint n [3], inout bit sat);
        longint          d, vperp [3], slip [3], c [3], dpara [3], t [3];
        longint          factor, k, g, dperp, oldv;
        longint unsigned magp, mags;
        logic [127:0]    yp;
        bit              ignore;
        d      = 0;
        ignore = 1'b0;
        for (int i = 0; i < 3; i++)
            d = fx_add(d, fx_mul(ball_vel[i], n[i], FRAC_W, sat), sat);
        cross_fx(n, ball_spin, c, sat);
        for (int i = 0; i < 3; i++) begin
            vperp[i] = fx_mul(d, n[i], FRAC_W, sat);
            slip[i]  = fx_sub(ball_vel[i], vperp[i], sat);
            slip[i]  = fx_add(slip[i], fx_mul(longint'(cfg_radius), c[i], FRAC_W, sat), sat);
        end
        magp = vec_length(vperp);
        mags = vec_length(slip);
        yp   = ({97'b0, cfg_gain} * {64'b0, magp}) >> FRAC_W;
        // zero slip or a ratio of at least one: full friction
        if (yp[127:64] != 0 || mags == 0 || yp[63:0] >= mags)
            factor = ONE;
        else
            factor = slip_fraction(yp[63:0], mags);
        k = fx_mul(factor, longint'(cfg_mu), FRAC_W, ignore);
        for (int i = 0; i < 3; i++) begin
            dperp    = fx_mul(ONE + longint'(cfg_cr), vperp[i], FRAC_W, sat);
            dperp    = clamp_word(-dperp, sat);
            dpara[i] = clamp_word(-fx_mul(k, slip[i], FRAC_W, sat), sat);
            oldv     = ball_vel[i];
            ball_vel[i] = fx_add(fx_add(ball_vel[i], dperp, sat), dpara[i], sat);
            ball_pos[i] = fx_add(ball_pos[i], oldv, sat);
        end
        g = fx_mul(longint'(cfg_coupling), longint'(cfg_radius), 24, sat);
        cross_fx(dpara, n, t, sat);
        for (int i = 0; i < 3; i++)
            ball_spin[i] = fx_add(ball_spin[i], fx_mul(g, t[i], FRAC_W, sat), sat);
    endfunction

    function automatic t_ball_state predict_step(logic [2:0] kind, logic [31:0] x,
                                                 logic [31:0] y, logic [31:0] z);
        t_ball_state r;
        longint      v [3];
        bit          sat;
        sat  = 1'b0;
        v[0] = longint'($signed(x));
        v[1] = longint'($signed(y));
        v[2] = longint'($signed(z));
        case (kind)
            KIND_TICK:   for (int i = 0; i < 3; i++)
                             ball_pos[i] = fx_add(ball_pos[i], ball_vel[i], sat);
            KIND_BOUNCE: bounce_ball(v, sat);
            KIND_LDP:    ball_pos  = v;
            KIND_LDV:    ball_vel  = v;
            KIND_LDW:    ball_spin = v;
            default:     ;  // spare kinds leave the state alone
        endcase
        for (int i = 0; i < 3; i++) begin
            r.f[i]     = ball_pos[i][31:0];
            r.f[3 + i] = ball_vel[i][31:0];
            r.f[6 + i] = ball_spin[i][31:0];
        end
        r.sat = sat;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // result checker: compares against the oldest expected state
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            automatic logic [31:0] got [9] = '{o_pos_x, o_pos_y, o_pos_z, o_vel_x, o_vel_y,
                                               o_vel_z, o_spin_x, o_spin_y, o_spin_z};
            automatic t_ball_state want;
            if (expected_states.size() == 0) begin
                $display("%0t: unexpected result word", $time);
                n_fail++;
            end else begin
                want = expected_states.pop_front();
                n_checked++;
                for (int i = 0; i < 9; i++)
                    if (got[i] !== want.f[i]) begin
                        $display("%0t: %s expected %h actual %h", $time, field_name[i],
                                 want.f[i], got[i]);
                        n_fail++;
                    end
                if (o_saturated !== want.sat) begin
                    $display("%0t: saturated expected %b actual %b", $time, want.sat,
                             o_saturated);
                    n_fail++;
                end
            end
        end
    end

    // random receiver stall bursts, none in the quiet tail
    initial begin
        forever begin
            @(negedge i_clk);
            if (!quiet_run && $urandom_range(0, 5) == 0) begin
                i_stall = 1'b1;
                repeat ($urandom_range(0, 3)) @(negedge i_clk);
            end else begin
                i_stall = 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    // one word on the input channel; valid stays high into the next word
    task automatic send_word(logic [2:0] kind, logic [31:0] x, logic [31:0] y,
                             logic [31:0] z, bit typed, t_ball_state want);
        t_ball_state pred;
        if (!quiet_run && $urandom_range(0, 4) == 0) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_kind  = kind;
        i_vec_x = x;
        i_vec_y = y;
        i_vec_z = z;
        do @(posedge i_clk); while (o_stall);
        pred = predict_step(kind, x, y, z);
        if (kind == KIND_BOUNCE) n_bounce++;
        if (pred.sat) n_sat++;
        expected_states.push_back(typed ? want : pred);
        @(negedge i_clk);
    endtask

    task automatic drain;
        i_valid = 1'b0;
        wait (expected_states.size() == 0);
        // every word makes a result, so an empty queue means all results are in
        repeat (8) @(negedge i_clk);
    endtask

    task automatic reg_write(logic [2:0] idx, logic [31:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_RADIUS:   cfg_radius   = data[30:0];
            REG_GAIN:     cfg_gain     = data[30:0];
            REG_MU:       cfg_mu       = data[16:0];
            REG_CR:       cfg_cr       = data[16:0];
            REG_COUPLING: cfg_coupling = data[23:0];
            default:      ;
        endcase
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // component of a loaded vector: mostly moderate, sometimes full range
    function automatic logic [31:0] rand_component();
        case ($urandom_range(0, 7))
            0:       return $urandom;
            1:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            2:       return 32'(-$signed(32'($urandom_range(0, 32'h00FF_FFFF))));
            default: return 32'($signed(32'($urandom_range(0, 32'h01FF_FFFF))) - 32'sh0100_0000);
        endcase
    endfunction

    // surface normal: mostly unit length along an axis or a diagonal
    task automatic rand_normal(output logic [31:0] n [3]);
        int axis;
        axis = $urandom_range(0, 2);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                n = '{32'h0, 32'h0, 32'h0};
                n[axis] = $urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000;
            end
            4, 5: begin   // 45 degrees, 0.7071 in Q16.16
                n = '{32'h0, 32'h0, 32'h0};
                n[axis]           = $urandom_range(0, 1) ? 32'h0000_B505 : 32'hFFFF_4AFB;
                n[(axis + 1) % 3] = $urandom_range(0, 1) ? 32'h0000_B505 : 32'hFFFF_4AFB;
            end
            6, 7: for (int i = 0; i < 3; i++)   // short, not normalized
                n[i] = 32'($signed(32'($urandom_range(0, 32'h0002_0000))) - 32'sh0001_0000);
            default: for (int i = 0; i < 3; i++) n[i] = rand_component();
        endcase
    endtask

    task automatic random_words(int count);
        logic [31:0] v [3];
        logic [2:0]  kind;
        t_ball_state none;
        for (int j = 0; j < count; j++) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7: begin
                    kind = KIND_BOUNCE;
                    rand_normal(v);
                end
                8, 9, 10, 11: kind = KIND_TICK;
                12, 13:       kind = KIND_LDV;
                14, 15:       kind = KIND_LDW;
                16, 17:       kind = KIND_LDP;
                default:      kind = 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
            endcase
            if (kind != KIND_BOUNCE)
                for (int i = 0; i < 3; i++) v[i] = rand_component();
            send_word(kind, v[0], v[1], v[2], 1'b0, none);
        end
    endtask

    t_ball_state zero_state;
    t_stim_row   directed [];

    initial begin
        cfg_radius   = RST_RADIUS;
        cfg_gain     = RST_GAIN;
        cfg_mu       = RST_MU;
        cfg_cr       = RST_CR;
        cfg_coupling = RST_COUPLING;
        for (int i = 0; i < 3; i++) begin
            ball_pos[i] = 0; ball_vel[i] = 0; ball_spin[i] = 0;
        end
        zero_state.f   = '{default: 32'h0};
        zero_state.sat = 1'b0;

        // typed rows: state after reset, loads of the extremes, and a tick
        // that clamps x while y and z stay in range
        directed = '{
            '{KIND_TICK, 32'h0, 32'h0, 32'h0, 1'b1, zero_state},
            '{KIND_LDP, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b1,
              '{'{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0, 32'h0, 32'h0,
                  32'h0, 32'h0, 32'h0}, 1'b0}},
            '{KIND_LDV, 32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1,
              '{'{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0001_0000, 32'h7FFF_FFFF,
                  32'h8000_0000, 32'h0, 32'h0, 32'h0}, 1'b0}},
            '{KIND_TICK, 32'h0, 32'h0, 32'h0, 1'b1,
              '{'{32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0001_0000,
                  32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0, 32'h0}, 1'b1}},
            // remaining rows checked by the predictor
            '{KIND_LDW, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0, zero_state},
            '{KIND_BOUNCE, 32'h0, 32'h0, 32'h0001_0000, 1'b0, zero_state},    // saturating
            '{KIND_LDP, 32'h0, 32'h0, 32'h0, 1'b0, zero_state},
            '{KIND_LDW, 32'h0, 32'h0, 32'h0, 1'b0, zero_state},
            '{KIND_LDV, 32'h0, 32'h0, 32'hFFFB_0000, 1'b0, zero_state},
            '{KIND_BOUNCE, 32'h0, 32'h0, 32'h0001_0000, 1'b0, zero_state},    // zero slip
            '{KIND_LDV, 32'h0003_0000, 32'h0, 32'hFFF0_0000, 1'b0, zero_state},
            '{KIND_BOUNCE, 32'h0, 32'h0, 32'h0001_0000, 1'b0, zero_state},    // huge ratio
            '{KIND_LDW, 32'h0000_8000, 32'hFFFF_0000, 32'h0002_0000, 1'b0, zero_state},
            '{KIND_LDV, 32'h0100_0000, 32'h0000_4000, 32'hFFFF_C000, 1'b0, zero_state},
            '{KIND_BOUNCE, 32'h0, 32'h0, 32'h0001_0000, 1'b0, zero_state},    // partial ratio
            '{KIND_BOUNCE, 32'h0000_B505, 32'h0000_B505, 32'h0, 1'b0, zero_state},
            '{KIND_BOUNCE, 32'h0000_8000, 32'h0, 32'h0, 1'b0, zero_state},    // non-unit
            '{KIND_BOUNCE, 32'h0, 32'h0, 32'h0, 1'b0, zero_state},            // zero normal
            '{KIND_BOUNCE, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0, zero_state},
            '{KIND_SPARE_LO, 32'hFFFF_FFFF, 32'h0, 32'h1234_5678, 1'b0, zero_state},
            '{KIND_SPARE_HI, 32'h0, 32'hFFFF_FFFF, 32'h0, 1'b0, zero_state},
            '{KIND_TICK, 32'h0, 32'h0, 32'h0, 1'b0, zero_state}
        };

        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (directed[r])
            send_word(directed[r].kind, directed[r].x, directed[r].y, directed[r].z,
                      directed[r].typed, directed[r].want);
        random_words(N_RANDOM / 6);

        // radius, gain and coupling at their top values (radius with bit 31 set), mu and cr at 1.0, one unmapped write
        drain();
        reg_write(REG_RADIUS, 32'hFFFF_FFFF);
        reg_write(REG_GAIN, 32'h7FFF_FFFF);
        reg_write(REG_MU, 32'h0001_0000);
        reg_write(REG_CR, 32'h0001_0000);
        reg_write(REG_COUPLING, 32'h00FF_FFFF);
        reg_write(REG_UNMAPPED, 32'hDEAD_BEEF);
        random_words(N_RANDOM / 6);

        // all registers zero
        drain();
        reg_write(REG_RADIUS, 32'h0);
        reg_write(REG_GAIN, 32'h0);
        reg_write(REG_MU, 32'h0);
        reg_write(REG_CR, 32'h0);
        reg_write(REG_COUPLING, 32'h0);
        random_words(N_RANDOM / 6);

        // masked writes and random settings
        drain();
        reg_write(REG_MU, 32'hFFFF_FFFF);
        reg_write(REG_CR, 32'h0003_FFFF);
        reg_write(REG_RADIUS, $urandom_range(0, 32'h0100_0000));
        reg_write(REG_GAIN, $urandom);
        reg_write(REG_COUPLING, $urandom);
        random_words(N_RANDOM / 6);

        // back to defaults; the sender holds off until the block has caught up
        drain();
        reg_write(REG_RADIUS, 32'(RST_RADIUS));
        reg_write(REG_GAIN, 32'(RST_GAIN));
        reg_write(REG_MU, 32'(RST_MU));
        reg_write(REG_CR, 32'(RST_CR));
        reg_write(REG_COUPLING, 32'(RST_COUPLING));
        random_words(N_RANDOM / 6);
        quiet_run = 1'b1;
        random_words(N_RANDOM - 5 * (N_RANDOM / 6));

        i_valid = 1'b0;
        wait (expected_states.size() == 0);
        repeat (300) @(negedge i_clk);

        $display("checked %0d result words: %0d bounces, %0d saturating steps,",
                 n_checked, n_bounce, n_sat);
        $display("five register settings including all-zero and all-max");
        if (n_fail == 0 && expected_states.size() == 0)
            $display("[ball_bounce_spin_step] OK");
        else
            $display("[ball_bounce_spin_step] ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
src/bbs_pkg.sv
src/bbs_datapath.sv
src/bbs_ctrl.sv
src/ball_bounce_spin_step.sv
verif/testbench.sv
